// ===== rtl/core/acache_pkg.sv =====
// Shared types, codes and constants of the associative cache.
`default_nettype none

package acache_pkg;

	// Operation codes of an input word.
	localparam logic [1:0] OP_GET   = 2'd0;
	localparam logic [1:0] OP_PUT   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Replacement policy codes.
	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_RAND = 1'b1;

	// Random pick generator and counter widths.
	localparam int          LFSR_BITS  = 16;
	localparam int          LFSR_CNT_W = 4;
	localparam logic [15:0] LFSR_SEED  = 16'hACE1;
	localparam int          COUNT_BITS = 32;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_MOD,
		ST_READ,
		ST_EVICT,
		ST_WRITE,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic pick_lru;
		logic pick_rand;
		logic mod_step;
		logic read_tgt;
		logic write;
		logic evict;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;
		logic scan_end;
		logic mod_last;
		logic is_get;
		logic random;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/acache_ctrl.sv =====
// Controller state machine of the associative cache.
`default_nettype none

module acache_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         op,
	input  wire acache_pkg::stat_t  stat,
	output acache_pkg::cmd_t        cmd,
	output logic                    busy
);

	acache_pkg::state_t state_q;
	acache_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acache_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			acache_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (op == acache_pkg::OP_GET || op == acache_pkg::OP_PUT) begin
						state_d = acache_pkg::ST_SCAN;
					end else begin
						state_d = acache_pkg::ST_DONE;
					end
				end
			end
			acache_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.match) begin
					state_d = acache_pkg::ST_WRITE;
				end else if (stat.scan_end) begin
					state_d = stat.is_get ? acache_pkg::ST_DONE : acache_pkg::ST_PICK;
				end
			end
			acache_pkg::ST_PICK: begin
				if (stat.random) begin
					cmd.pick_rand = 1'b1;
					state_d       = acache_pkg::ST_MOD;
				end else begin
					cmd.pick_lru = 1'b1;
					state_d      = acache_pkg::ST_READ;
				end
			end
			acache_pkg::ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_d = acache_pkg::ST_READ;
				end
			end
			acache_pkg::ST_READ: begin
				cmd.read_tgt = 1'b1;
				state_d      = acache_pkg::ST_EVICT;
			end
			acache_pkg::ST_EVICT: begin
				cmd.evict = 1'b1;
				cmd.write = 1'b1;
				state_d   = acache_pkg::ST_DONE;
			end
			acache_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = acache_pkg::ST_DONE;
			end
			acache_pkg::ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = acache_pkg::ST_IDLE;
			end
			default: begin
				state_d = acache_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/acache_dp.sv =====
// Datapath of the associative cache: slot memories, scan, pick and counters.
`default_nettype none

module acache_dp #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int DATA_BITS  = 32,
	parameter int STAMP_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire acache_pkg::cmd_t              cmd,
	output acache_pkg::stat_t                  stat,
	input  wire logic [1:0]                    op,
	input  wire logic [KEY_BITS-1:0]           key,
	input  wire logic [DATA_BITS-1:0]          entry_data,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_policy,
	output logic                               done,
	output logic                               hit,
	output logic [DATA_BITS-1:0]               hit_data,
	output logic                               evicted,
	output logic [KEY_BITS-1:0]                evicted_key,
	output logic [acache_pkg::COUNT_BITS-1:0]  hit_count,
	output logic [acache_pkg::COUNT_BITS-1:0]  miss_count
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [acache_pkg::LFSR_CNT_W-1:0] BIT_TOP = acache_pkg::LFSR_CNT_W'(1);
	// Reciprocal of ENTRIES, exact for every LFSR value with this shift.
	localparam int DIV_SHIFT = acache_pkg::LFSR_BITS + IDX_W;
	localparam int RECIP_W   = acache_pkg::LFSR_BITS + 1;
	localparam int PROD_W    = acache_pkg::LFSR_BITS + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << DIV_SHIFT) + ENTRIES - 1) / ENTRIES);
	localparam logic [acache_pkg::LFSR_BITS-1:0] ENTRIES_L =
		acache_pkg::LFSR_BITS'(ENTRIES);

	// Slot memories and valid bits.
	logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
	logic [DATA_BITS-1:0]  data_mem  [ENTRIES];
	logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;

	logic [KEY_BITS-1:0]   key_rd_q;
	logic [DATA_BITS-1:0]  data_rd_q;
	logic [STAMP_BITS-1:0] stamp_rd_q;

	// Current command word.
	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [DATA_BITS-1:0]  data_q;

	// Scan, pick and policy state.
	logic [IDX_W-1:0]      idx_q;
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic [IDX_W-1:0]      target_q;
	logic [STAMP_BITS-1:0] min_stamp_q;
	logic [IDX_W-1:0]      min_idx_q;
	logic                  policy_q;
	logic [STAMP_BITS-1:0] clock_q;
	logic [acache_pkg::LFSR_BITS-1:0]  lfsr_q;
	logic [acache_pkg::LFSR_CNT_W-1:0] bit_q;
	logic [acache_pkg::LFSR_BITS-1:0]  quot_q;

	// Result and counter state.
	logic                  done_q;
	logic                  hit_q;
	logic [DATA_BITS-1:0]  hit_data_q;
	logic                  evicted_q;
	logic [KEY_BITS-1:0]   evicted_key_q;
	logic [acache_pkg::COUNT_BITS-1:0] hits_q;
	logic [acache_pkg::COUNT_BITS-1:0] misses_q;

	logic                  is_get;
	logic                  is_put;
	logic                  match;
	logic [IDX_W-1:0]      rd_addr;
	logic                  rd_en;
	logic [acache_pkg::LFSR_BITS-1:0] lfsr_next;
	logic [PROD_W-1:0]     quot_prod;
	logic [acache_pkg::LFSR_BITS-1:0] rem_full;

	assign is_get = (op_q == acache_pkg::OP_GET);
	assign is_put = (op_q == acache_pkg::OP_PUT);

	// A get matches a valid slot with its key; a put matches an empty slot.
	assign match = cmp_vld_s1 && (is_get ? (valid_q[cmp_idx_s1] && key_rd_q == key_q)
	                                     : !valid_q[cmp_idx_s1]);

	always_comb begin
		stat          = '0;
		stat.match    = cmd.scan && match;
		stat.scan_end = cmd.scan && cmp_vld_s1 && !match && (cmp_idx_s1 == LAST_IDX);
		stat.mod_last = (bit_q == '0);
		stat.is_get   = is_get;
		stat.random   = (policy_q == acache_pkg::POLICY_RAND);
	end

	// Random pick: LFSR step, then the quotient by a reciprocal multiply and
	// the remainder by a multiply and subtract in the following cycle.
	assign lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
	assign quot_prod = PROD_W'(lfsr_q) * PROD_W'(RECIP);
	assign rem_full  = lfsr_q - quot_q * ENTRIES_L;

	// Memory read port, registered.
	assign rd_addr = cmd.read_tgt ? target_q : idx_q;
	assign rd_en   = cmd.scan || cmd.read_tgt;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_q   <= key_mem[rd_addr];
			data_rd_q  <= data_mem[rd_addr];
			stamp_rd_q <= stamp_mem[rd_addr];
		end
	end

	// Memory write port at the chosen slot.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			stamp_mem[target_q] <= clock_q;
			if (is_put) begin
				key_mem[target_q]  <= key_q;
				data_mem[target_q] <= data_q;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			key_q  <= key;
			data_q <= entry_data;
		end
		if (cmd.scan) begin
			cmp_idx_s1 <= idx_q;
		end
		if (cmd.scan && cmp_vld_s1) begin
			if (cmp_idx_s1 == '0 || stamp_rd_q < min_stamp_q) begin
				min_stamp_q <= stamp_rd_q;
				min_idx_q   <= cmp_idx_s1;
			end
		end
		if (cmd.scan && match) begin
			target_q <= cmp_idx_s1;
		end else if (cmd.pick_lru) begin
			target_q <= min_idx_q;
		end else if (cmd.mod_step && bit_q == '0) begin
			target_q <= rem_full[IDX_W-1:0];
		end
		if (cmd.mod_step && bit_q != '0) begin
			quot_q <= acache_pkg::LFSR_BITS'(quot_prod >> DIV_SHIFT);
		end
	end

	// Control state: scan counter, valid bits, clock, LFSR, policy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			valid_q    <= '0;
			clock_q    <= STAMP_BITS'(1);
			lfsr_q     <= acache_pkg::LFSR_SEED;
			bit_q      <= '0;
			policy_q   <= acache_pkg::POLICY_LRU;
		end else begin
			cmp_vld_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end
			if (cmd.write) begin
				if (is_put) begin
					valid_q[target_q] <= 1'b1;
				end
				if (clock_q != '1) begin
					clock_q <= clock_q + 1'b1;
				end
			end
			if (cmd.pick_rand) begin
				lfsr_q <= lfsr_next;
				bit_q  <= BIT_TOP;
			end else if (cmd.mod_step) begin
				bit_q <= bit_q - 1'b1;
			end
			if (cfg_we) begin
				policy_q <= cfg_policy;
			end
		end
	end

	// Result fields and saturating counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q        <= 1'b0;
			hit_q         <= 1'b0;
			hit_data_q    <= '0;
			evicted_q     <= 1'b0;
			evicted_key_q <= '0;
			hits_q        <= '0;
			misses_q      <= '0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				hit_q         <= 1'b0;
				hit_data_q    <= '0;
				evicted_q     <= 1'b0;
				evicted_key_q <= '0;
			end
			if (cmd.scan && match && is_get) begin
				hit_q      <= 1'b1;
				hit_data_q <= data_rd_q;
			end
			if (cmd.evict) begin
				evicted_q     <= 1'b1;
				evicted_key_q <= key_rd_q;
			end
			if (cmd.finish) begin
				if (op_q == acache_pkg::OP_CLEAR) begin
					hits_q   <= '0;
					misses_q <= '0;
				end else if (is_get) begin
					if (hit_q) begin
						if (hits_q != '1) begin
							hits_q <= hits_q + 1'b1;
						end
					end else if (misses_q != '1) begin
						misses_q <= misses_q + 1'b1;
					end
				end
			end
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign hit_data    = hit_data_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign hit_count   = hits_q;
	assign miss_count  = misses_q;

	// The result strobe lasts a single cycle.
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	// A word never reports both a hit and an eviction.
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !(hit_q && evicted_q))
		else $error("hit and eviction reported together");

	// Slot writes stay inside the cache.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (int'(target_q) < ENTRIES))
		else $error("slot write beyond the last entry");

	// The LFSR never locks up at zero.
	assert property (@(posedge clk) disable iff (!arst_n) lfsr_q != '0)
		else $error("random pick generator reached zero");

	// The access clock never wraps to zero.
	assert property (@(posedge clk) disable iff (!arst_n) clock_q != '0)
		else $error("access clock wrapped");

endmodule

`default_nettype wire

// ===== rtl/core/assoc_cache_lru_random_replace.sv =====
// Top level of the fully associative cache with LRU or random replacement.
//
// Channel   Direction  Handshake                  Word
// command   in         start, busy                op, key, entry_data
// result    out        done (one-cycle strobe)    hit, hit_data, evicted, evicted_key,
//                                                 hit_count, miss_count
// config    in         cfg_valid, cfg_ready       cfg_policy
//
// A word is taken when start is high and busy is low; its result strobe follows
// the last busy cycle. The slot scan reads one entry a cycle from the slot
// memories and stops at a get hit or, for a put, at an empty slot. A get miss
// ends after the full scan; a put with no empty slot goes on to an LRU or a random
// replacement (a reciprocal multiply, then a multiply and subtract, reduce the LFSR
// value modulo ENTRIES). A clear or the unused code skips the scan.
// Reset clears the valid bits at once, so no clearing pass is needed. The
// receiver cannot stall the result.
`default_nettype none

module assoc_cache_lru_random_replace #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int DATA_BITS  = 32,
	parameter int STAMP_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    op,
	input  wire logic [KEY_BITS-1:0]           key,
	input  wire logic [DATA_BITS-1:0]          entry_data,
	output logic                               done,
	output logic                               hit,
	output logic [DATA_BITS-1:0]               hit_data,
	output logic                               evicted,
	output logic [KEY_BITS-1:0]                evicted_key,
	output logic [acache_pkg::COUNT_BITS-1:0]  hit_count,
	output logic [acache_pkg::COUNT_BITS-1:0]  miss_count,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_policy
);

	acache_pkg::cmd_t  cmd;
	acache_pkg::stat_t stat;

	// The policy register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	acache_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	acache_dp #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.DATA_BITS  (DATA_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.key         (key),
		.entry_data  (entry_data),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_policy  (cfg_policy),
		.done        (done),
		.hit         (hit),
		.hit_data    (hit_data),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.hit_count   (hit_count),
		.miss_count  (miss_count)
	);

endmodule

`default_nettype wire
